// ----- design/mnst_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the midi note sustain tracker
// no dependencies; imported by the top level and the note ram
package mnst_pkg;

   // parameter defaults
   localparam int NUM_NOTES_DEF = 128;
   localparam int TIME_BITS_DEF = 32;

   // midi constants
   localparam logic [6:0] DAMPER_CC       = 7'd64;
   localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;

   // action codes
   localparam logic [2:0] ACT_NOTE_ON    = 3'd0;
   localparam logic [2:0] ACT_NOTE_OFF   = 3'd1;
   localparam logic [2:0] ACT_CONTROLLER = 3'd2;
   localparam logic [2:0] ACT_READ       = 3'd3;
   localparam logic [2:0] ACT_ACTIVATE   = 3'd4;
   localparam logic [2:0] ACT_DEACTIVATE = 3'd5;

   // register indexes (word address bit 2)
   localparam logic REG_LISTEN_CHANNEL = 1'b0;
   localparam logic REG_PEDAL_ENABLE   = 1'b1;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // input item
   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  midi_channel;
      logic [6:0]  number;
      logic [6:0]  value;
      logic [31:0] now_ms;
   } req_item_type;

   // result item
   typedef struct packed {
      logic        note_pressed;
      logic        note_sounding;
      logic [6:0]  note_velocity;
      logic [31:0] note_on_time;
      logic        pedal_down;
      logic        is_active;
   } rsp_item_type;

endpackage

// ----- design/mnst_ram.sv -----
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
// depends on mnst_pkg for the default depth
module mnst_ram
   import mnst_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = NUM_NOTES_DEF
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/midi_note_sustain_tracker_unit.sv -----
`timescale 1ns / 1ps
// midi note tracker with damper pedal: note flags, velocity and onset time
// depends on mnst_pkg and mnst_ram
//
// usage
//   req channel carries one midi event item per handshake (note on, note off,
//   controller, read, activate, deactivate). every item gives exactly one rsp
//   item with the addressed note's entry after the event, the pedal state and
//   the active state. csr port (apb style, pready tied high) holds
//   listen_channel at 0x0 and pedal_enable at 0x4; write only while idle.
//   pipeline: the accepting edge does the ram read and fills the read stage;
//   the output register takes the item when the read stage advances, which
//   waits while a held rsp item blocks the output register.
//   throughput: one item per cycle while rsp_ready stays high, set by the
//   single read port of the velocity/time ram, which is read once per item.
//   the pressed and sounding flags live in flip-flop vectors so that pedal
//   release and deactivate act on all notes at once.
//   reset: synchronous, clears flags, pedal, active state, ram valid bits and
//   registers; no clearing pass, req_ready is high right after.
//   stall: a held rsp item stays in the output register, one more item waits
//   in the read stage, then req_ready drops until rsp_ready returns.
module midi_note_sustain_tracker_unit
   import mnst_pkg::*;
#(
   parameter int NUM_NOTES = NUM_NOTES_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_payload,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_payload,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W  = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;
   localparam int WORD_W = 7 + TIME_BITS;

   // read stage contents
   typedef struct packed {
      logic                 pressed;
      logic                 sounding;
      logic                 note_ok;
      logic                 fwd;
      logic                 vld;
      logic [6:0]           fwd_vel;
      logic [TIME_BITS-1:0] fwd_time;
      logic                 pedal;
      logic                 active;
   } pend_type;

   // configuration registers
   logic [3:0] listen_ff;
   logic       pedal_en_ff;
   logic       csr_wr;

   // tracker state
   logic [NUM_NOTES-1:0] pressed_ff, pressed_in;
   logic [NUM_NOTES-1:0] sounding_ff, sounding_in;
   logic [NUM_NOTES-1:0] vld_ff, vld_in;
   logic                 pedal_ff, pedal_in;
   logic                 active_ff, active_in;

   // pipeline
   logic         pend_vld_ff;
   pend_type     pend_ff, pend_in;
   logic         rsp_vld_ff;
   rsp_item_type rsp_ff, rsp_in;
   logic         adv;
   logic         accept;

   // event decode
   logic [IDX_W-1:0]     idx;
   logic                 note_ok, chan_ok;
   logic                 on_hit, off_hit, ped_hit, ped_new;
   logic [63:0]          now_ext;
   logic [TIME_BITS-1:0] now_t;

   // ram
   logic [WORD_W-1:0]    ram_wdata, ram_rdata;
   logic [6:0]           rd_vel;
   logic [TIME_BITS-1:0] rd_time;
   logic [6:0]           out_vel;
   logic [TIME_BITS-1:0] out_time;
   logic [63:0]          out_time_ext;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff   <= 4'd0;
         pedal_en_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_LISTEN_CHANNEL: listen_ff   <= csr_pwdata[3:0];
            REG_PEDAL_ENABLE:   pedal_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_LISTEN_CHANNEL: csr_prdata = {{(CSR_DATA_W-4){1'b0}}, listen_ff};
         REG_PEDAL_ENABLE:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, pedal_en_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // handshake
   assign adv       = pend_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !pend_vld_ff || adv;
   assign accept    = req_valid && req_ready;

   // event decode
   assign idx     = req_payload.number[IDX_W-1:0];
   assign note_ok = 32'(req_payload.number) < NUM_NOTES;
   assign chan_ok = req_payload.midi_channel == listen_ff;
   assign on_hit  = (req_payload.action == ACT_NOTE_ON) && active_ff && chan_ok && note_ok;
   assign off_hit = (req_payload.action == ACT_NOTE_OFF) && active_ff && chan_ok && note_ok;
   assign ped_hit = (req_payload.action == ACT_CONTROLLER) && active_ff && chan_ok
                    && (req_payload.number == DAMPER_CC) && pedal_en_ff;
   assign ped_new = req_payload.value >= PEDAL_THRESHOLD;
   assign now_ext = 64'(req_payload.now_ms);
   assign now_t   = now_ext[TIME_BITS-1:0];

   // next state of flags, pedal and active
   always_comb begin
      pressed_in  = pressed_ff;
      sounding_in = sounding_ff;
      vld_in      = vld_ff;
      pedal_in    = pedal_ff;
      active_in   = active_ff;
      if (accept) begin
         unique case (req_payload.action)
            ACT_NOTE_ON: begin
               if (on_hit) begin
                  pressed_in[idx]  = 1'b1;
                  sounding_in[idx] = 1'b1;
                  vld_in[idx]      = 1'b1;
               end
            end
            ACT_NOTE_OFF: begin
               if (off_hit) begin
                  pressed_in[idx] = 1'b0;
                  if (!pedal_ff) begin
                     sounding_in[idx] = 1'b0;
                  end
               end
            end
            ACT_CONTROLLER: begin
               if (ped_hit) begin
                  pedal_in = ped_new;
                  // pedal release stops every note whose key is up
                  if (!ped_new) begin
                     sounding_in = sounding_ff & pressed_ff;
                  end
               end
            end
            ACT_ACTIVATE: begin
               active_in = 1'b1;
            end
            ACT_DEACTIVATE: begin
               pressed_in  = '0;
               sounding_in = '0;
               active_in   = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff  <= '0;
         sounding_ff <= '0;
         vld_ff      <= '0;
         pedal_ff    <= 1'b0;
         active_ff   <= 1'b0;
      end else begin
         pressed_ff  <= pressed_in;
         sounding_ff <= sounding_in;
         vld_ff      <= vld_in;
         pedal_ff    <= pedal_in;
         active_ff   <= active_in;
      end
   end

   // velocity and onset time store; note on writes while the same item reads
   assign ram_wdata = {req_payload.value, now_t};

   mnst_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_NOTES)
   ) u_note_ram (
      .clock (clock),
      .we    (accept && on_hit),
      .waddr (idx),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (idx),
      .rdata (ram_rdata)
   );

   // read stage capture, new values forwarded for a note on
   always_comb begin
      pend_in.pressed  = note_ok && pressed_in[idx];
      pend_in.sounding = note_ok && sounding_in[idx];
      pend_in.note_ok  = note_ok;
      pend_in.fwd      = on_hit;
      pend_in.vld      = note_ok && vld_ff[idx];
      pend_in.fwd_vel  = req_payload.value;
      pend_in.fwd_time = now_t;
      pend_in.pedal    = pedal_in;
      pend_in.active   = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else if (accept) begin
         pend_vld_ff <= 1'b1;
      end else if (adv) begin
         pend_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

   // result assembly; entries never written read as zero
   assign rd_vel  = ram_rdata[WORD_W-1 -: 7];
   assign rd_time = ram_rdata[TIME_BITS-1:0];

   always_comb begin
      if (pend_ff.fwd) begin
         out_vel  = pend_ff.fwd_vel;
         out_time = pend_ff.fwd_time;
      end else if (pend_ff.vld && pend_ff.note_ok) begin
         out_vel  = rd_vel;
         out_time = rd_time;
      end else begin
         out_vel  = '0;
         out_time = '0;
      end
      out_time_ext = 64'(out_time);
      rsp_in.note_pressed  = pend_ff.pressed;
      rsp_in.note_sounding = pend_ff.sounding;
      rsp_in.note_velocity = out_vel;
      rsp_in.note_on_time  = out_time_ext[31:0];
      rsp_in.pedal_down    = pend_ff.pedal;
      rsp_in.is_active     = pend_ff.active;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // a waiting item moves into a free output register
   assert property (@(posedge clock) disable iff (reset)
      (pend_vld_ff && (!rsp_vld_ff || rsp_ready)) |=> rsp_vld_ff)
      else $error("read stage item not moved to output");

   // a held key always sounds
   assert property (@(posedge clock) disable iff (reset)
      (pressed_ff & ~sounding_ff) == '0)
      else $error("pressed note not sounding");

   // with the pedal up only held keys sound
   assert property (@(posedge clock) disable iff (reset)
      !pedal_ff |-> ((sounding_ff & ~pressed_ff) == '0))
      else $error("released note sounding with pedal up");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for midi_note_sustain_tracker_unit: drives midi events,
// predicts every result item and programs the registers over the csr port
// depends on mnst_pkg and the design sources
module tb
   import mnst_pkg::*;
();

   localparam int NUM_NOTES = NUM_NOTES_DEF;
   localparam int PHASES    = 6;

   // actions with no defined meaning, reported as a read
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   midi_note_sustain_tracker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow copy of the note table and registers
   bit [NUM_NOTES-1:0] pressed_vec;
   bit [NUM_NOTES-1:0] sounding_vec;
   bit [6:0]           velocity_mem [NUM_NOTES];
   bit [31:0]          onset_mem [NUM_NOTES];
   bit                 pedal_now;
   bit                 active_now;
   bit [3:0]           listen_cfg;
   bit                 pedal_cfg;

   req_item_type event_backlog[$];
   rsp_item_type predicted_reports[$];

   int  fail_count;
   int  items_taken;
   int  results_seen;
   int  note_ons_taken;
   int  pedal_releases;
   int  req_gap;
   int  rsp_hold;
   bit  took;
   bit  calm;

   // event generator state
   bit        gen_active;
   bit [3:0]  gen_chan;
   bit [6:0]  note_base;
   bit [31:0] stamp_ms;

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", predicted_reports.size());
      $display("** midi_note_sustain_tracker_unit: FAILED **");
      $finish;
   end

   // apply one item to the shadow table and return the report it causes
   function automatic rsp_item_type track_event(input req_item_type ev);
      rsp_item_type rep;
      bit           chan_hit;
      bit           note_hit;
      chan_hit = active_now && (ev.midi_channel == listen_cfg);
      note_hit = int'(ev.number) < NUM_NOTES;
      case (ev.action)
         ACT_NOTE_ON: begin
            if (chan_hit && note_hit) begin
               velocity_mem[ev.number] = ev.value;
               onset_mem[ev.number]    = ev.now_ms;
               pressed_vec[ev.number]  = 1'b1;
               sounding_vec[ev.number] = 1'b1;
               note_ons_taken++;
            end
         end
         ACT_NOTE_OFF: begin
            if (chan_hit && note_hit) begin
               pressed_vec[ev.number] = 1'b0;
               if (!pedal_now) sounding_vec[ev.number] = 1'b0;
            end
         end
         ACT_CONTROLLER: begin
            if (chan_hit && ev.number == DAMPER_CC && pedal_cfg) begin
               pedal_now = ev.value >= PEDAL_THRESHOLD;
               // pedal up: only keys still held keep sounding
               if (!pedal_now) begin
                  sounding_vec &= pressed_vec;
                  pedal_releases++;
               end
            end
         end
         ACT_ACTIVATE: active_now = 1'b1;
         ACT_DEACTIVATE: begin
            pressed_vec  = '0;
            sounding_vec = '0;
            active_now   = 1'b0;
         end
         default: ;
      endcase
      rep = '0;
      if (note_hit) begin
         rep.note_pressed  = pressed_vec[ev.number];
         rep.note_sounding = sounding_vec[ev.number];
         rep.note_velocity = velocity_mem[ev.number];
         rep.note_on_time  = onset_mem[ev.number];
      end
      rep.pedal_down = pedal_now;
      rep.is_active  = active_now;
      return rep;
   endfunction

   // mostly well-formed traffic on the listen channel around a small key range
   function automatic req_item_type random_event();
      req_item_type ev;
      int           pick;
      stamp_ms += $urandom_range(0, 300);
      if ($urandom_range(0, 19) == 0) stamp_ms = $urandom();
      ev.now_ms       = stamp_ms;
      ev.midi_channel = gen_chan;
      ev.number       = ($urandom_range(0, 99) < 75) ? 7'(note_base + $urandom_range(0, 11))
                                                     : 7'($urandom_range(0, 127));
      ev.value        = 7'($urandom_range(0, 127));
      pick            = $urandom_range(0, 99);
      if (!gen_active && $urandom_range(0, 3) != 0) begin
         ev.action = ACT_ACTIVATE;
      end else if (pick < 30) begin
         ev.action = ACT_NOTE_ON;
      end else if (pick < 55) begin
         ev.action = ACT_NOTE_OFF;
      end else if (pick < 70) begin
         ev.action = ACT_CONTROLLER;
         if ($urandom_range(0, 4) != 0) ev.number = DAMPER_CC;
         if ($urandom_range(0, 3) == 0)
            ev.value = 7'(PEDAL_THRESHOLD - 2 + $urandom_range(0, 3));
      end else if (pick < 84) begin
         ev.action = ACT_READ;
      end else if (pick < 88) begin
         ev.action = ACT_ACTIVATE;
      end else if (pick < 91) begin
         ev.action = ACT_DEACTIVATE;
      end else if (pick < 93) begin
         ev.action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
      end else begin
         // noise on any channel
         case ($urandom_range(0, 2))
            0: ev.action = ACT_NOTE_ON;
            1: ev.action = ACT_NOTE_OFF;
            default: begin
               ev.action = ACT_CONTROLLER;
               ev.number = DAMPER_CC;
            end
         endcase
         ev.midi_channel = 4'($urandom_range(0, 15));
      end
      if (ev.action == ACT_ACTIVATE) gen_active = 1'b1;
      if (ev.action == ACT_DEACTIVATE) gen_active = 1'b0;
      return ev;
   endfunction

   task automatic queue_event(input logic [2:0] act, input logic [3:0] chan,
                              input logic [6:0] num, input logic [6:0] val,
                              input logic [31:0] stamp);
      req_item_type ev;
      ev.action       = act;
      ev.midi_channel = chan;
      ev.number       = num;
      ev.value        = val;
      ev.now_ms       = stamp;
      event_backlog.push_back(ev);
   endtask

   // apb write, then read back through the same port
   task automatic program_register(input logic idx, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] readback;
      mask = (idx == REG_LISTEN_CHANNEL) ? 32'hF : 32'h1;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_LISTEN_CHANNEL) listen_cfg = data[3:0];
      else pedal_cfg = data[0];
      if ((readback & mask) !== (data & mask)) begin
         fail_count++;
         if (fail_count <= 10)
            $display("register %0d read back %0h, expected %0h", idx, readback & mask,
                     data & mask);
      end
   endtask

   // sampled at the rising edge, where all driven inputs are settled
   task automatic wait_drained();
      do @(posedge clock);
      while (event_backlog.size() != 0 || req_valid || predicted_reports.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // input driver: one item held until accepted, random gaps between items
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (event_backlog.size() != 0) begin
            req_payload <= event_backlog.pop_front();
            req_valid   <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) rsp_hold = $urandom_range(1, 7);
      end
   end

   // monitor: check results first, then record the item accepted at this edge
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         took <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("result item with nothing outstanding");
            end else begin
               want = predicted_reports.pop_front();
               if (rsp_payload.note_pressed  !== want.note_pressed  ||
                   rsp_payload.note_sounding !== want.note_sounding ||
                   rsp_payload.note_velocity !== want.note_velocity ||
                   rsp_payload.note_on_time  !== want.note_on_time  ||
                   rsp_payload.pedal_down    !== want.pedal_down    ||
                   rsp_payload.is_active     !== want.is_active) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("result %0d expected: pressed %0b sounding %0b vel %0d",
                              results_seen, want.note_pressed, want.note_sounding,
                              want.note_velocity, " time %h pedal %0b active %0b",
                              want.note_on_time, want.pedal_down, want.is_active);
                     $display("result %0d got     : pressed %0b sounding %0b vel %0d",
                              results_seen, rsp_payload.note_pressed,
                              rsp_payload.note_sounding, rsp_payload.note_velocity,
                              " time %h pedal %0b active %0b", rsp_payload.note_on_time,
                              rsp_payload.pedal_down, rsp_payload.is_active);
                  end
               end
            end
            results_seen++;
         end
         took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predicted_reports.push_back(track_event(req_payload));
            items_taken++;
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      program_register(REG_LISTEN_CHANNEL, 32'd5);
      program_register(REG_PEDAL_ENABLE, 32'd1);

      // directed: inactive block, extremes, channel filter, pedal handling
      queue_event(ACT_READ, 4'd5, 7'd0, 7'd0, 32'd0);
      queue_event(ACT_NOTE_ON, 4'd5, 7'd10, 7'd99, 32'd1);
      queue_event(ACT_CONTROLLER, 4'd5, DAMPER_CC, 7'd127, 32'd0);
      queue_event(ACT_ACTIVATE, 4'd5, 7'd10, 7'd0, 32'd0);
      queue_event(ACT_NOTE_ON, 4'd5, 7'd0, 7'd127, 32'hFFFF_FFFF);
      // zero velocity still presses the key
      queue_event(ACT_NOTE_ON, 4'd5, 7'd127, 7'd0, 32'd0);
      queue_event(ACT_NOTE_ON, 4'd4, 7'd60, 7'd50, 32'h1234);
      queue_event(ACT_CONTROLLER, 4'd5, DAMPER_CC, 7'd127, 32'd0);
      queue_event(ACT_NOTE_OFF, 4'd5, 7'd0, 7'd0, 32'd0);
      queue_event(ACT_CONTROLLER, 4'd5, 7'd7, 7'd0, 32'd0);
      queue_event(ACT_CONTROLLER, 4'd6, DAMPER_CC, 7'd0, 32'd0);
      queue_event(ACT_CONTROLLER, 4'd5, DAMPER_CC, PEDAL_THRESHOLD, 32'd0);
      queue_event(ACT_CONTROLLER, 4'd5, DAMPER_CC, PEDAL_THRESHOLD - 7'd1, 32'd0);
      queue_event(ACT_READ, 4'd5, 7'd127, 7'd0, 32'd0);
      queue_event(ACT_SPARE_6, 4'd5, 7'd0, 7'd127, 32'hFFFF_FFFF);
      queue_event(ACT_SPARE_7, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF);
      queue_event(ACT_NOTE_OFF, 4'd5, 7'd127, 7'd0, 32'd0);
      queue_event(ACT_NOTE_ON, 4'd5, 7'd64, 7'd64, 32'h8000_0000);
      queue_event(ACT_CONTROLLER, 4'd5, DAMPER_CC, 7'd127, 32'd0);
      // deactivate keeps the pedal, and acts again when already inactive
      queue_event(ACT_DEACTIVATE, 4'd5, 7'd64, 7'd0, 32'd0);
      queue_event(ACT_DEACTIVATE, 4'd5, 7'd64, 7'd0, 32'd0);
      queue_event(ACT_NOTE_OFF, 4'd5, 7'd64, 7'd0, 32'd0);
      queue_event(ACT_ACTIVATE, 4'd0, 7'd0, 7'd0, 32'd0);
      queue_event(ACT_CONTROLLER, 4'd5, DAMPER_CC, 7'd0, 32'd0);
      wait_drained();
      gen_active = active_now;

      // random phases over several register settings, quiet at the end
      for (int p = 0; p < PHASES; p++) begin
         gen_chan  = (p == 0) ? 4'd15 : (p == 1) ? 4'd0 : 4'($urandom_range(0, 15));
         note_base = 7'($urandom_range(0, 116));
         calm      = (p == 3) || (p == PHASES - 1);
         program_register(REG_LISTEN_CHANNEL, {28'd0, gen_chan});
         program_register(REG_PEDAL_ENABLE, (p == 1 || p == 4) ? 32'd0 : 32'd1);
         for (int n = 0; n < 255; n++) event_backlog.push_back(random_event());
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("covered %0d events, %0d checked results, %0d note ons taken",
               items_taken, results_seen, note_ons_taken);
      $display("%0d pedal releases over %0d register settings, with and without stalls",
               pedal_releases, PHASES + 1);
      if (fail_count == 0 && predicted_reports.size() == 0) begin
         $display("** midi_note_sustain_tracker_unit: PASSED **");
      end else begin
         $display("** midi_note_sustain_tracker_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/mnst_pkg.sv
design/mnst_ram.sv
design/midi_note_sustain_tracker_unit.sv
verif/tb.sv
